FILE: hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, register indexes, opcodes and datapath commands.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_OSS   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CAL_A = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CAL_B = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CAL_C = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_COEF  = 3'd4;

    localparam logic [47:0] COEF_RESET = 48'd16286033841118;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // datapath micro-operations, one per sequencer step
    typedef enum logic [4:0] {
        C_NOP,
        C_T_X1,      // x1 = asr((ut-ac6)*ac5,15), den = x1+md
        C_T_DIVST,   // start mc<<11 / den
        C_T_FIN,     // b5 = x1+q, value
        C_P_B6,      // b6 = b5-4000, up
        C_P_SQ,      // sq = asr(b6*b6,12)
        C_P_X1,      // acc = asr(sq*b2,11)
        C_P_X2,      // acc += asr(ac2*b6,11)
        C_P_B3,      // b3
        C_P_Y1,      // acc = asr(ac3*b6,13)
        C_P_Y2,      // acc += asr(b1*sq,16)
        C_P_B4,      // b4 = ac4*(x3+32768)>>15
        C_P_B7,      // b7 = (up-b3)*(50000>>oss)
        C_P_DIVST,   // start unsigned divide
        C_P_PQ,      // p from quotient
        C_P_Z1,      // t = asr(p,8)
        C_P_Z2,      // t = t*t
        C_P_Z3,      // acc = asr(t*mg,16)
        C_P_Z4,      // acc += asr(p*mh,16)
        C_P_FIN      // p += asr(acc+mi,4)
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAITDIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic div_busy;
        logic t_zero;    // temperature divisor zero
        logic p_zero;    // b4 zero
    } t_status;

endpackage

FILE: hw/rtl/bsc_divider.sv
// ----------------------------------------------------------------------------
// Barometric compensation divider
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_q[31]} - {1'b0, r_den};
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_q = i_num;
            n_rem = '0;
            n_cnt = 6'd32;
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_q;
endmodule

FILE: hw/rtl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// Barometric compensation datapath
// Registers, one multiplier step per command, shared divider, B5 state.
// ----------------------------------------------------------------------------
module bsc_datapath import bsc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [23:0]   i_raw,
    input  t_cmd          i_cmd,
    input  logic          i_set_fault,
    input  logic [1:0]    i_oss,
    input  logic [63:0]   i_cal_a,
    input  logic [63:0]   i_cal_b,
    input  logic [31:0]   i_cal_c,
    input  logic [47:0]   i_coef,
    output t_status       o_status,
    output logic [31:0]   o_value,
    output logic          o_fault
);
    logic [31:0] r_b5;
    logic [31:0] r_raw;
    logic [31:0] r_a, r_b6, r_sq, r_acc, r_b3, r_b4, r_b7, r_p, r_t, r_up;
    logic [31:0] r_den;
    logic        r_neg;
    logic        r_fault;
    logic        r_big;

    logic        w_start;
    logic [31:0] w_num, w_dden, w_quot;
    logic        w_busy;

    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2;
    logic [31:0] w_mc, w_md, w_mg, w_mh, w_mi;
    logic [31:0] w_ma, w_mb, w_prod;
    logic [31:0] w_x3, w_b3s, w_mca;
    logic [31:0] w_scale;
    logic [31:0] w_tq, w_b5n, w_tv;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        asr32 = $signed(v) >>> s;
    endfunction

    assign w_ac1 = sx16(i_cal_a[15:0]);
    assign w_ac2 = sx16(i_cal_a[31:16]);
    assign w_ac3 = sx16(i_cal_a[47:32]);
    assign w_ac4 = {16'd0, i_cal_a[63:48]};
    assign w_ac5 = {16'd0, i_cal_b[15:0]};
    assign w_ac6 = {16'd0, i_cal_b[31:16]};
    assign w_b1  = sx16(i_cal_b[47:32]);
    assign w_b2  = sx16(i_cal_b[63:48]);
    assign w_mc  = sx16(i_cal_c[15:0]);
    assign w_md  = sx16(i_cal_c[31:16]);
    assign w_mg  = sx16(i_coef[15:0]);
    assign w_mh  = sx16(i_coef[31:16]);
    assign w_mi  = sx16(i_coef[47:32]);
    assign w_scale = 32'd50000 >> i_oss;

    // one 32x32 multiplier (low word), operands chosen by command
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd)
            C_T_X1:  begin w_ma = {16'd0, r_raw[15:0]} - w_ac6; w_mb = w_ac5; end
            C_P_SQ:  begin w_ma = r_b6; w_mb = r_b6; end
            C_P_X1:  begin w_ma = r_sq; w_mb = w_b2; end
            C_P_X2:  begin w_ma = w_ac2; w_mb = r_b6; end
            C_P_Y1:  begin w_ma = w_ac3; w_mb = r_b6; end
            C_P_Y2:  begin w_ma = w_b1; w_mb = r_sq; end
            C_P_B4:  begin w_ma = w_ac4; w_mb = w_x3 + 32'd32768; end
            C_P_B7:  begin w_ma = r_up - r_b3; w_mb = w_scale; end
            C_P_Z2:  begin w_ma = r_t; w_mb = r_t; end
            C_P_Z3:  begin w_ma = r_t; w_mb = w_mg; end
            C_P_Z4:  begin w_ma = r_p; w_mb = w_mh; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_x3  = asr32(r_acc + 32'd2, 5'd2);
    assign w_b3s = ((w_ac1 << 2) + r_acc) << i_oss;
    assign w_mca = w_mc << 11;

    // temperature finish: quotient dropped when the divisor was zero
    assign w_tq  = r_neg ? (32'd0 - w_quot) : w_quot;
    assign w_b5n = r_a + ((r_den == 32'd0) ? 32'd0 : w_tq);
    assign w_tv  = asr32(w_b5n + 32'd8, 5'd4);

    // divider operands
    always_comb begin
        w_start = 1'b0;
        w_num = '0;
        w_dden = '0;
        if (i_cmd == C_T_DIVST) begin
            w_start = 1'b1;
            w_num = w_mca[31] ? (32'd0 - w_mca) : w_mca;
            w_dden = r_den[31] ? (32'd0 - r_den) : r_den;
        end else if (i_cmd == C_P_DIVST) begin
            w_start = 1'b1;
            w_num = r_big ? r_b7 : (r_b7 << 1);
            w_dden = r_b4;
        end
    end

    bsc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_dden),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5 <= '0;
        end else if (i_cmd == C_T_FIN) begin
            r_b5 <= w_b5n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw <= {8'd0, i_raw};
            r_fault <= 1'b0;
        end
        if (i_set_fault) begin
            r_fault <= 1'b1;
        end
        unique case (i_cmd)
            C_T_X1: begin
                r_a <= asr32(w_prod, 5'd15);
                r_den <= asr32(w_prod, 5'd15) + w_md;
            end
            C_T_DIVST: r_neg <= w_mca[31] ^ r_den[31];
            C_T_FIN: r_p <= sx16(w_tv[15:0]);
            C_P_B6: begin
                r_b6 <= r_b5 - 32'd4000;
                r_up <= r_raw >> (4'd8 - {2'd0, i_oss});
            end
            C_P_SQ: r_sq <= asr32(w_prod, 5'd12);
            C_P_X1: r_acc <= asr32(w_prod, 5'd11);
            C_P_X2: r_acc <= r_acc + asr32(w_prod, 5'd11);
            C_P_B3: r_b3 <= asr32(w_b3s + 32'd2, 5'd2);
            C_P_Y1: r_acc <= asr32(w_prod, 5'd13);
            C_P_Y2: r_acc <= r_acc + asr32(w_prod, 5'd16);
            C_P_B4: r_b4 <= w_prod >> 15;
            C_P_B7: begin
                r_b7 <= w_prod;
                r_big <= w_prod[31];
            end
            C_P_PQ: r_p <= r_big ? (w_quot << 1) : w_quot;
            C_P_Z1: r_t <= asr32(r_p, 5'd8);
            C_P_Z2: r_t <= w_prod;
            C_P_Z3: r_acc <= asr32(w_prod, 5'd16);
            C_P_Z4: r_acc <= r_acc + asr32(w_prod, 5'd16);
            C_P_FIN: r_p <= r_p + asr32(r_acc + w_mi, 5'd4);
            default: ;
        endcase
    end

    assign o_status.div_busy = w_busy;
    assign o_status.t_zero = (r_den == 32'd0);
    assign o_status.p_zero = (r_b4 == 32'd0);
    assign o_value = r_fault ? 32'd0 : r_p;
    assign o_fault = r_fault;
endmodule

FILE: hw/rtl/bsc_controller.sv
// ----------------------------------------------------------------------------
// Barometric compensation controller
// Steps the datapath through the temperature or pressure command sequence.
// ----------------------------------------------------------------------------
module bsc_controller import bsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_load,
    output logic    o_out_valid,
    output logic    o_kind,
    output t_cmd    o_cmd,
    output logic    o_set_fault
);
    t_state r_state, n_state;
    t_cmd   r_step, n_step;
    logic   r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= C_NOP;
            r_kind <= OP_TEMP;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_kind <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_kind = r_kind;
        o_in_ready = 1'b0;
        o_load = 1'b0;
        o_out_valid = 1'b0;
        o_cmd = C_NOP;
        o_set_fault = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_load = 1'b1;
                    n_kind = i_op;
                    n_step = (i_op == OP_PRESS) ? C_P_B6 : C_T_X1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd = r_step;
                n_step = t_cmd'(r_step + 5'd1);
                if (r_step == C_T_DIVST || r_step == C_P_DIVST) begin
                    n_state = S_WAITDIV;
                end
                if (r_step == C_T_X1) begin
                    // divisor known next cycle; checked at T_DIVST
                end
                if (r_step == C_T_DIVST && i_status.t_zero) begin
                    o_set_fault = 1'b1;
                end
                if (r_step == C_P_DIVST && i_status.p_zero) begin
                    o_set_fault = 1'b1;
                    n_state = S_OUT;
                end
                if (r_step == C_P_FIN) begin
                    n_state = S_OUT;
                end
            end
            S_WAITDIV: begin
                if (!i_status.div_busy) begin
                    o_cmd = r_step;
                    if (r_step == C_T_FIN) begin
                        n_state = S_OUT;
                    end else begin
                        n_step = t_cmd'(r_step + 5'd1);
                        n_state = S_RUN;
                    end
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_kind = r_kind;
endmodule

FILE: hw/rtl/baro_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation unit
// Integer temperature and pressure compensation with packed calibration.
// ----------------------------------------------------------------------------
// One item at a time. Both paths use the shared radix-2 divider; the pressure
// path also runs ten steps through a single 32x32 multiplier. The result is
// held on the output until taken; the next item is accepted after that.
module baro_sensor_compensation_unit import bsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // raw_adc[23:0]
    input  logic                s_axis_tuser,   // op
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // value[31:0], div_fault[32], zero fill
    output logic                m_axis_tuser,   // kind
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);
    logic [1:0]  r_oss;
    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [47:0] r_coef;
    t_status     w_status;
    t_cmd        w_cmd;
    logic        w_load, w_set_fault, w_fault;
    logic [31:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_coef <= COEF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OSS:   r_oss <= i_cfg_data[1:0];
                REG_CAL_A: r_cal_a <= i_cfg_data;
                REG_CAL_B: r_cal_b <= i_cfg_data;
                REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                REG_COEF:  r_coef <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    bsc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_load      (w_load),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_cmd       (w_cmd),
        .o_set_fault (w_set_fault)
    );

    bsc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_raw       (s_axis_tdata),
        .i_cmd       (w_cmd),
        .i_set_fault (w_set_fault),
        .i_oss       (r_oss),
        .i_cal_a     (r_cal_a),
        .i_cal_b     (r_cal_b),
        .i_cal_c     (r_cal_c),
        .i_coef      (r_coef),
        .o_status    (w_status),
        .o_value     (w_value),
        .o_fault     (w_fault)
    );

    assign m_axis_tdata = {7'd0, w_fault, w_value};
endmodule

FILE: hw/rtl/bsc_checker.sv
// ----------------------------------------------------------------------------
// Barometric compensation port checker
// Port-level properties of the compensation unit.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // a fault always carries a zero value
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("fault with nonzero value");

    // never accept while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output pending");

    // an accepted item is not followed by an immediate result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

    // pending result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

bind baro_sensor_compensation_unit bsc_checker u_bsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/baro_sensor_compensation_unit_tb.sv
// ----------------------------------------------------------------------------
// Barometric compensation unit testbench
// Drives raw temperature and pressure words through the stream ports, predicts
// every result with an in-bench integer model of the compensation math and
// compares kind, value and fault flag in order. Calibration is rewritten
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit_tb;
    import bsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        fault;
    } t_comp_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [39:0]         m_axis_tdata;   // value[31:0], div_fault[32], zero fill
    logic                m_axis_tuser;   // kind
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    baro_sensor_compensation_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic [1:0]  oss_set;
    logic [63:0] cal_a, cal_b;
    logic [31:0] cal_c;
    logic [47:0] coefs;
    logic [31:0] b5_kept;

    t_comp_result pending_results[$];
    int  errors;
    bit  sink_idle_en;   // random stalls on the output side
    int  sink_hold;      // cycles of forced hold-off on the output side
    bit  src_idle_en;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_comp_result compensate(logic op, logic [23:0] raw);
        t_comp_result r;
        logic [31:0] x1, x2, x3, den, t, up, b6, sq, b3, b4, b7, p;
        r.kind = op;
        r.fault = 1'b0;
        r.value = '0;
        if (op == OP_TEMP) begin
            x1 = asr(({16'd0, raw[15:0]} - {16'd0, cal_b[31:16]}) * {16'd0, cal_b[15:0]}, 15);
            den = x1 + sx16(cal_c[31:16]);
            x2 = '0;
            if (den == 0) r.fault = 1'b1;
            else x2 = quot_trunc(sx16(cal_c[15:0]) << 11, den);
            b5_kept = x1 + x2;
            if (!r.fault) begin
                t = asr(b5_kept + 32'd8, 4);
                r.value = sx16(t[15:0]);
            end
        end else begin
            up = {8'd0, raw} >> (8 - oss_set);
            b6 = b5_kept - 32'd4000;
            sq = asr(b6 * b6, 12);
            x1 = asr(sq * sx16(cal_b[63:48]), 11);
            x2 = asr(sx16(cal_a[31:16]) * b6, 11);
            x3 = x1 + x2;
            b3 = asr(((sx16(cal_a[15:0]) * 4 + x3) << oss_set) + 32'd2, 2);
            x1 = asr(sx16(cal_a[47:32]) * b6, 13);
            x2 = asr(sx16(cal_b[47:32]) * sq, 16);
            x3 = asr(x1 + x2 + 32'd2, 2);
            b4 = ({16'd0, cal_a[63:48]} * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> oss_set);
            if (b4 == 0) begin
                r.fault = 1'b1;
            end else begin
                if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
                else p = (b7 / b4) << 1;
                x1 = asr(p, 8);
                x1 = x1 * x1;
                x1 = asr(x1 * sx16(coefs[15:0]), 16);
                x2 = asr(p * sx16(coefs[31:16]), 16);
                r.value = p + asr(x1 + x2 + sx16(coefs[47:32]), 4);
            end
        end
        return r;
    endfunction

    // result checker and output-side stall generator
    always @(posedge i_clk) begin
        t_comp_result got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.value = m_axis_tdata[31:0];
            got.fault = m_axis_tdata[32];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d value=%0d fault=%0d",
                         $time, got.kind, $signed(got.value), got.fault);
            end else begin
                exp_r = pending_results.pop_front();
                if (got.kind !== exp_r.kind) begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
                end
                if (got.value !== exp_r.value) begin
                    errors++;
                    $display("%0t: value expected %0d actual %0d", $time,
                             $signed(exp_r.value), $signed(got.value));
                end
                if (got.fault !== exp_r.fault) begin
                    errors++;
                    $display("%0t: div_fault expected %0d actual %0d", $time,
                             exp_r.fault, got.fault);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 36);
        end
    end

    // registers change only once every item has come back
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_OSS:   oss_set = data[1:0];
            REG_CAL_A: cal_a = data;
            REG_CAL_B: cal_b = data;
            REG_CAL_C: cal_c = data[31:0];
            REG_COEF:  coefs = data[47:0];
            default: ;
        endcase
    endtask

    // tvalid stays up after an accept until the next item, an idle, a register write or a drain
    task automatic send_sample(logic op, logic [23:0] raw);
        while (src_idle_en && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= raw;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(compensate(op, raw));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic load_datasheet_cal();
        write_reg(REG_CAL_A, {16'd32741, 16'hC760, 16'hFFBE, 16'd408});
        write_reg(REG_CAL_B, {16'd4, 16'd6190, 16'd23153, 16'd32757});
        write_reg(REG_CAL_C, {32'd0, 16'd2868, 16'hD4C6});
        write_reg(REG_COEF, {16'd0, 16'd3791, 16'hE343, 16'd3038});
    endtask

    task automatic random_cal();
        write_reg(REG_CAL_A, {$urandom, $urandom});
        write_reg(REG_CAL_B, {$urandom, $urandom});
        write_reg(REG_CAL_C, {32'd0, $urandom});
        write_reg(REG_COEF, {$urandom, $urandom});
        write_reg(REG_OSS, 64'($urandom_range(3)));
    endtask

    task automatic test_reset_defaults();
        // pressure with no prior temperature: b5 zero, ac4 zero -> fault
        send_sample(OP_PRESS, 24'h5D23_00);
        send_sample(OP_TEMP, 24'h0);
        drain();
    endtask

    task automatic test_directed();
        int o;
        load_datasheet_cal();
        for (o = 0; o < 4; o++) begin
            write_reg(REG_OSS, {62'd0, o[1:0]});
            send_sample(OP_TEMP, 24'h006C_FA);
            send_sample(OP_PRESS, 24'h5D23_00);
            send_sample(OP_PRESS, 24'hFFFFFF);
            send_sample(OP_PRESS, 24'h000000);
        end
        send_sample(OP_TEMP, 24'hFFFFFF);
        send_sample(OP_TEMP, 24'h000000);
        // temperature divisor zero: ac5=0 so x1=0, md=0
        write_reg(REG_CAL_C, {32'd0, 16'd0, 16'h8000});
        write_reg(REG_CAL_B, 64'h0);
        send_sample(OP_TEMP, 24'h1234);
        send_sample(OP_PRESS, 24'h800000);
        // out-of-list index is ignored
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CAL_C, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEF, 64'h0000_FFFF_FFFF_FFFF);
        send_sample(OP_TEMP, 24'hABCDEF);
        send_sample(OP_PRESS, 24'hFFFFFF);
        drain();
    endtask

    task automatic test_random(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                drain();
                if ($urandom_range(1)) load_datasheet_cal();
                else random_cal();
                write_reg(REG_OSS, 64'($urandom_range(3)));
            end
            src_idle_en = !(i >= 300 && i < 420);
            sink_idle_en = src_idle_en;
            send_sample($urandom_range(99) < 40 ? OP_TEMP : OP_PRESS, 24'($urandom));
        end
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        drain();
    endtask

    task automatic test_backpressure();
        int i;
        sink_hold = 400;
        for (i = 0; i < 6; i++) send_sample(1'($urandom_range(1)), 24'($urandom));
        drain();
        // sender pauses until everything is back, then resumes
        for (i = 0; i < 6; i++) send_sample(1'($urandom_range(1)), 24'($urandom));
        drain();
    endtask

    initial begin
        errors = 0;
        sink_hold = 0;
        sink_idle_en = 1'b1;
        src_idle_en = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TEMP;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_OSS;
        i_cfg_data = '0;
        oss_set = '0;
        cal_a = '0;
        cal_b = '0;
        cal_c = '0;
        coefs = COEF_RESET;
        b5_kept = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random(1370);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_divider.sv
hw/rtl/bsc_datapath.sv
hw/rtl/bsc_controller.sv
hw/rtl/baro_sensor_compensation_unit.sv
hw/rtl/bsc_checker.sv
tb/baro_sensor_compensation_unit_tb.sv
